// ===== design/sws_pkg.sv =====
package sws_pkg;

	localparam int TASK_SLOTS_DEF = 32;

	localparam logic [24:0] EPOCH_USEC_RESET = 25'd32000000;
	localparam logic [9:0]  GUARD_USEC_RESET = 10'd40;

	// configuration register indexes
	localparam logic REG_EPOCH_USEC = 1'b0;
	localparam logic REG_GUARD_USEC = 1'b1;

	typedef enum logic [1:0] {
		OP_SLEEP    = 2'd0,
		OP_MATCH    = 2'd1,
		OP_OVERFLOW = 2'd2,
		OP_SETUP    = 2'd3
	} op_t;

	// classified command held in the queue between front and back
	typedef struct packed {
		op_t         op;
		logic        in_range;
		logic [4:0]  task_req;
		logic [31:0] wake_epoch;
		logic [24:0] wake_usec;
		logic [24:0] timer_now;
		logic        blocks_on_object;
		logic        enable;
		logic [7:0]  priority_req;
	} cmd_t;

	typedef struct packed {
		logic [31:0] woken_mask;
		logic        any_woken;
		logic [7:0]  top_priority;
		logic [25:0] compare_value;
		logic        must_block;
		logic [31:0] epoch_now;
	} res_t;

endpackage

// ===== design/sws_ram.sv =====
module sws_ram
	import sws_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/sws_front.sv =====
module sws_front
	import sws_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [4:0]  task_req,
	input  logic [31:0] wake_epoch,
	input  logic [24:0] wake_usec,
	input  logic [24:0] timer_now,
	input  logic        blocks_on_object,
	input  logic        enable,
	input  logic [7:0]  priority_req,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	// two-entry queue
	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       new_cmd;

	assign busy      = (count_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_comb begin
		new_cmd                  = '0;
		new_cmd.op               = op_t'(opcode);
		new_cmd.in_range         = ({2'b00, task_req} < 7'(TASK_SLOTS));
		new_cmd.task_req         = task_req;
		new_cmd.wake_epoch       = wake_epoch;
		new_cmd.wake_usec        = wake_usec;
		new_cmd.timer_now        = timer_now;
		new_cmd.blocks_on_object = blocks_on_object;
		new_cmd.enable           = enable;
		new_cmd.priority_req     = priority_req;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== design/sws_back.sv =====
module sws_back
	import sws_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [24:0] epoch_usec,
	input  logic [9:0]  guard_usec,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        done,
	output res_t        res
);

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	logic [31:0]           epoch_q;
	logic [25:0]           cmp_q;
	logic [TASK_SLOTS-1:0] armed_q;
	logic [TASK_SLOTS-1:0] on_q;
	logic [TASK_SLOTS-1:0] run_q;

	logic [24:0]  now_q;
	logic [24:0]  next_q;
	logic [31:0]  mask_q;
	logic         any_q;
	logic [7:0]   top_q;
	logic [SW-1:0] issue_q;
	logic          issuing_q;
	logic          eval_vld_s1;
	logic [SW-1:0] eval_idx_s1;

	logic          done_q;
	res_t          res_q;

	// table ports
	logic [SW-1:0] slot;
	logic          tw_we;
	logic          rank_we;
	logic [31:0]   e_rd;
	logic [24:0]   u_rd;
	logic [7:0]    r_rd;

	// sleep decision
	logic         ep_ok;
	logic         ep_same;
	logic         guard_ok;
	logic         sleep_ok;
	logic         blk;
	logic [25:0]  cmp_new;

	// scan evaluation
	logic         part;
	logic         expired;
	logic [6:0]   eval_ix7;

	assign slot = SW'({2'b00, cmd.task_req});
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	assign tw_we   = cmd_pop && (cmd.op == OP_SLEEP) && cmd.in_range && ep_ok;
	assign rank_we = cmd_pop && (cmd.op == OP_SETUP) && cmd.in_range;

	sws_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_epoch_ram (
		.clk(clk), .we(tw_we), .waddr(slot), .wdata(cmd.wake_epoch),
		.raddr(issue_q), .rdata(e_rd)
	);

	sws_ram #(.WIDTH(25), .DEPTH(TASK_SLOTS)) u_usec_ram (
		.clk(clk), .we(tw_we), .waddr(slot), .wdata(cmd.wake_usec),
		.raddr(issue_q), .rdata(u_rd)
	);

	sws_ram #(.WIDTH(8), .DEPTH(TASK_SLOTS)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(slot), .wdata(cmd.priority_req),
		.raddr(issue_q), .rdata(r_rd)
	);

	always_comb begin
		ep_ok    = (cmd.wake_epoch >= epoch_q);
		ep_same  = (cmd.wake_epoch == epoch_q);
		guard_ok = ({1'b0, cmd.wake_usec} > ({1'b0, cmd.timer_now} + {16'd0, guard_usec}));
		sleep_ok = cmd.in_range && ep_ok && (!ep_same || guard_ok);
		blk      = cmd.in_range && (cmd.blocks_on_object || sleep_ok);
		cmp_new  = cmp_q;
		if (cmd.in_range && ep_same && guard_ok && ({1'b0, cmd.wake_usec} < cmp_q)) begin
			cmp_new = {1'b0, cmd.wake_usec};
		end
	end

	always_comb begin
		part     = on_q[eval_idx_s1] && !run_q[eval_idx_s1] && armed_q[eval_idx_s1];
		expired  = (e_rd < epoch_q) || ((e_rd == epoch_q) && (u_rd <= now_q));
		eval_ix7 = 7'(eval_idx_s1);
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && ((cmd.op == OP_MATCH) || (cmd.op == OP_OVERFLOW))) begin
			now_q <= cmd.timer_now;
		end
		if (cmd_pop) begin
			res_q.woken_mask    <= '0;
			res_q.any_woken     <= 1'b0;
			res_q.top_priority  <= '0;
			res_q.must_block    <= (cmd.op == OP_SLEEP) && blk;
			res_q.epoch_now     <= epoch_q;
			res_q.compare_value <= (cmd.op == OP_SLEEP) ? cmp_new : cmp_q;
		end
		if (state_q == ST_FIN) begin
			res_q.woken_mask   <= mask_q;
			res_q.any_woken    <= any_q;
			res_q.top_priority <= top_q;
			res_q.must_block   <= 1'b0;
			res_q.epoch_now    <= epoch_q;
			res_q.compare_value <= (next_q < epoch_usec) ? {1'b0, next_q}
				: ({1'b0, epoch_usec} + 26'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			epoch_q     <= '0;
			cmp_q       <= {1'b0, EPOCH_USEC_RESET} + 26'd1;
			armed_q     <= '0;
			on_q        <= '0;
			run_q       <= '0;
			next_q      <= '0;
			mask_q      <= '0;
			any_q       <= 1'b0;
			top_q       <= '0;
			issue_q     <= '0;
			issuing_q   <= 1'b0;
			eval_vld_s1 <= 1'b0;
			eval_idx_s1 <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN) ||
				(cmd_pop && ((cmd.op == OP_SLEEP) || (cmd.op == OP_SETUP)));
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_SLEEP: begin
								cmp_q <= cmp_new;
								if (tw_we) begin
									armed_q[slot] <= 1'b1;
								end
								if (blk) begin
									run_q[slot] <= 1'b0;
								end
							end
							OP_SETUP: begin
								if (cmd.in_range) begin
									on_q[slot]    <= cmd.enable;
									run_q[slot]   <= cmd.enable;
									armed_q[slot] <= 1'b0;
								end
							end
							default: begin
								if (cmd.op == OP_OVERFLOW) begin
									epoch_q <= epoch_q + 32'd1;
								end
								next_q    <= epoch_usec;
								mask_q    <= '0;
								any_q     <= 1'b0;
								top_q     <= '0;
								issue_q   <= SW'(1);
								issuing_q <= 1'b1;
								state_q   <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// issuing stops in the cycle before the last slot is evaluated
					eval_vld_s1 <= issuing_q;
					eval_idx_s1 <= issue_q;
					if (issuing_q) begin
						if (issue_q == LAST) begin
							issuing_q <= 1'b0;
						end else begin
							issue_q <= issue_q + SW'(1);
						end
					end
					if (eval_vld_s1) begin
						if (part && expired) begin
							armed_q[eval_idx_s1] <= 1'b0;
							run_q[eval_idx_s1]   <= 1'b1;
							if (eval_ix7 < 7'd32) begin
								mask_q[eval_ix7[4:0]] <= 1'b1;
							end
							if (!any_q || (r_rd > top_q)) begin
								top_q <= r_rd;
							end
							any_q <= 1'b1;
						end else if (part && (e_rd == epoch_q) && (u_rd < next_q)) begin
							next_q <= u_rd;
						end
						if (eval_idx_s1 == LAST) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					cmp_q   <= (next_q < epoch_usec) ? {1'b0, next_q}
						: ({1'b0, epoch_usec} + 26'd1);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== design/sleep_wake_scanner_top.sv =====
// sleep/wake scanner: wake-up table of a sleeping task scheduler
// command channel: an item transfers on a rising edge with start high and
//   busy low; opcode selects sleep request, compare match, epoch overflow
//   or task setup, the other fields travel with it
// a front queue of two entries takes items while the back end works, so
//   busy rises only when both entries are held
// result channel: one result per item, shown for exactly one cycle with done
//   high; the receiver cannot stall, so results are never held back
// processing: sleep and setup items finish with a registered done once the
//   back end takes them; match and overflow items walk slots 1 up to
//   TASK_SLOTS-1, one slot a cycle through the registered table read, then
//   pass a finish state; the back end takes no new item until the scan is
//   through, so the scan sets the throughput
// configuration: cfg_valid/cfg_ready with cfg_index 0 epoch_usec and
//   1 guard_usec; cfg_ready is always high, write only while idle
// reset: arst_n clears the queue, epoch counter and all task flags, sets
//   the compare value to the reset epoch length plus one and restores the
//   register defaults; table contents matter only once a slot is armed
module sleep_wake_scanner_top
	import sws_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [4:0]  task_req,
	input  logic [31:0] wake_epoch,
	input  logic [24:0] wake_usec,
	input  logic [24:0] timer_now,
	input  logic        blocks_on_object,
	input  logic        enable,
	input  logic [7:0]  priority_req,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// result channel
	output logic        done,
	output logic [31:0] woken_mask,
	output logic        any_woken,
	output logic [7:0]  top_priority,
	output logic [25:0] compare_value,
	output logic        must_block,
	output logic [31:0] epoch_now
);

	logic [24:0] epoch_usec_q;
	logic [9:0]  guard_usec_q;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_usec_q <= EPOCH_USEC_RESET;
			guard_usec_q <= GUARD_USEC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_EPOCH_USEC) begin
				epoch_usec_q <= cfg_data[24:0];
			end else if (cfg_index == REG_GUARD_USEC) begin
				guard_usec_q <= cfg_data[9:0];
			end
		end
	end

	// front: takes the transfer, classifies it and queues it
	sws_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.opcode(opcode), .task_req(task_req),
		.wake_epoch(wake_epoch), .wake_usec(wake_usec),
		.timer_now(timer_now), .blocks_on_object(blocks_on_object),
		.enable(enable), .priority_req(priority_req),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	// back: owns the task table and runs the slot scan
	sws_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.epoch_usec(epoch_usec_q), .guard_usec(guard_usec_q),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.done(done), .res(res)
	);

	assign woken_mask    = res.woken_mask;
	assign any_woken     = res.any_woken;
	assign top_priority  = res.top_priority;
	assign compare_value = res.compare_value;
	assign must_block    = res.must_block;
	assign epoch_now     = res.epoch_now;

endmodule

// ===== tb/tb_sleep_wake_scanner_top.sv =====
module tb_sleep_wake_scanner_top;
	import sws_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = TASK_SLOTS_DEF;
	localparam int CYCLE_CAP  = 600000;
	localparam int DRAIN_WAIT = 2 * SLOTS + 10;

	// one command as the testbench builds it
	typedef struct {
		op_t         op;
		logic [4:0]  slot;
		logic [31:0] w_epoch;
		logic [24:0] w_usec;
		logic [24:0] now;
		logic        obj;
		logic        en;
		logic [7:0]  prio;
	} sched_cmd_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0]  opcode;
	logic [4:0]  task_req;
	logic [31:0] wake_epoch;
	logic [24:0] wake_usec;
	logic [24:0] timer_now;
	logic        blocks_on_object;
	logic        enable;
	logic [7:0]  priority_req;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [31:0] woken_mask;
	logic        any_woken;
	logic [7:0]  top_priority;
	logic [25:0] compare_value;
	logic        must_block;
	logic [31:0] epoch_now;

	// shadow of the wake table and registers
	logic [24:0] sh_epoch_usec;
	logic [9:0]  sh_guard_usec;
	logic [31:0] sh_epoch;
	logic [31:0] sh_wake_epoch [SLOTS];
	logic [24:0] sh_wake_usec [SLOTS];
	logic        sh_armed [SLOTS];
	logic        sh_on [SLOTS];
	logic        sh_running [SLOTS];
	logic [7:0]  sh_rank [SLOTS];
	logic [25:0] sh_compare;

	res_t pending_results[$];
	int   fail_count;
	int   cycle_count;
	bit   idle_on;

	sleep_wake_scanner_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.task_req         (task_req),
		.wake_epoch       (wake_epoch),
		.wake_usec        (wake_usec),
		.timer_now        (timer_now),
		.blocks_on_object (blocks_on_object),
		.enable           (enable),
		.priority_req     (priority_req),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.woken_mask       (woken_mask),
		.any_woken        (any_woken),
		.top_priority     (top_priority),
		.compare_value    (compare_value),
		.must_block       (must_block),
		.epoch_now        (epoch_now)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("[sleep_wake_scanner_top] ERROR");
			$finish;
		end
	end

	// bring the shadow table back to its reset state
	task automatic clear_wake_table();
		sh_epoch_usec = EPOCH_USEC_RESET;
		sh_guard_usec = GUARD_USEC_RESET;
		sh_epoch      = '0;
		sh_compare    = {1'b0, EPOCH_USEC_RESET} + 26'd1;
		for (int i = 0; i < SLOTS; i++) begin
			sh_wake_epoch[i] = '0;
			sh_wake_usec[i]  = '0;
			sh_armed[i]      = 1'b0;
			sh_on[i]         = 1'b0;
			sh_running[i]    = 1'b0;
			sh_rank[i]       = '0;
		end
	endtask

	// walk slots 1 and up, wake expired tasks and re-arm the compare value
	task automatic scan_wake_table(input logic [24:0] now, inout res_t r);
		logic [24:0] next_us;
		next_us = sh_epoch_usec;
		for (int i = 1; i < SLOTS; i++) begin
			if (sh_on[i] && !sh_running[i] && sh_armed[i]) begin
				if (sh_wake_epoch[i] < sh_epoch ||
				    (sh_wake_epoch[i] == sh_epoch && sh_wake_usec[i] <= now)) begin
					sh_armed[i]     = 1'b0;
					sh_running[i]   = 1'b1;
					r.woken_mask[i] = 1'b1;
					if (!r.any_woken || sh_rank[i] > r.top_priority)
						r.top_priority = sh_rank[i];
					r.any_woken = 1'b1;
				end else if (sh_wake_epoch[i] == sh_epoch && sh_wake_usec[i] < next_us) begin
					next_us = sh_wake_usec[i];
				end
			end
		end
		sh_compare = (next_us < sh_epoch_usec) ? {1'b0, next_us}
		                                       : {1'b0, sh_epoch_usec} + 26'd1;
	endtask

	// outcome of one command against the shadow table
	task automatic predict_wake_result(input sched_cmd_t c, output res_t r);
		logic sleeps;
		r = '0;
		sleeps = 1'b0;
		case (c.op)
			OP_SLEEP: begin
				if (c.w_epoch >= sh_epoch) begin
					sh_wake_epoch[c.slot] = c.w_epoch;
					sh_wake_usec[c.slot]  = c.w_usec;
					sh_armed[c.slot]      = 1'b1;
					if (c.w_epoch == sh_epoch) begin
						if (32'(c.w_usec) > 32'(c.now) + 32'(sh_guard_usec)) begin
							if ({1'b0, c.w_usec} < sh_compare)
								sh_compare = {1'b0, c.w_usec};
							sleeps = 1'b1;
						end
					end else begin
						sleeps = 1'b1;
					end
				end
				if (c.obj || sleeps) begin
					r.must_block = 1'b1;
					sh_running[c.slot] = 1'b0;
				end
			end
			OP_MATCH: scan_wake_table(c.now, r);
			OP_OVERFLOW: begin
				sh_epoch = sh_epoch + 32'd1;
				scan_wake_table(c.now, r);
			end
			default: begin
				sh_on[c.slot]      = c.en;
				sh_rank[c.slot]    = c.prio;
				sh_running[c.slot] = c.en;
				sh_armed[c.slot]   = 1'b0;
			end
		endcase
		r.compare_value = sh_compare;
		r.epoch_now     = sh_epoch;
	endtask

	// one command transfer, with an optional random gap in front
	task automatic send_command(input sched_cmd_t c);
		res_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start            <= 1'b1;
		opcode           <= c.op;
		task_req         <= c.slot;
		wake_epoch       <= c.w_epoch;
		wake_usec        <= c.w_usec;
		timer_now        <= c.now;
		blocks_on_object <= c.obj;
		enable           <= c.en;
		priority_req     <= c.prio;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_wake_result(c, r);
		pending_results.push_back(r);
	endtask

	// wait for every result, then let the block settle
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_EPOCH_USEC)
			sh_epoch_usec = val[24:0];
		else
			sh_guard_usec = val[9:0];
	endtask

	function automatic sched_cmd_t make_cmd(op_t op, int slot, logic [31:0] we,
	                                        logic [24:0] wu, logic [24:0] now,
	                                        logic obj, logic en, logic [7:0] prio);
		sched_cmd_t c;
		c.op      = op;
		c.slot    = slot[4:0];
		c.w_epoch = we;
		c.w_usec  = wu;
		c.now     = now;
		c.obj     = obj;
		c.en      = en;
		c.prio    = prio;
		return c;
	endfunction

	// mostly well-formed traffic: setup, sleeps near the guard edge, scans
	function automatic sched_cmd_t random_command();
		sched_cmd_t c;
		int pick;
		c.slot = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 7));
		c.now  = ($urandom_range(0, 9) == 0) ? 25'($urandom)
		                                      : 25'($urandom_range(0, sh_epoch_usec));
		c.obj  = $urandom_range(0, 3) == 0;
		c.en   = $urandom_range(0, 4) != 0;
		c.prio = 8'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			c.w_epoch = sh_epoch;
		else if (pick < 8)
			c.w_epoch = sh_epoch + $urandom_range(1, 3);
		else if (pick < 9)
			c.w_epoch = (sh_epoch != 0) ? sh_epoch - 32'd1 : sh_epoch;
		else
			c.w_epoch = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			c.w_usec = c.now + sh_guard_usec + 25'($urandom_range(0, 6)) - 25'd3;
		else if (pick < 9)
			c.w_usec = 25'($urandom_range(0, sh_epoch_usec));
		else
			c.w_usec = 25'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c.op = OP_SLEEP;
		else if (pick < 68)
			c.op = OP_MATCH;
		else if (pick < 78)
			c.op = OP_OVERFLOW;
		else
			c.op = OP_SETUP;
		return c;
	endfunction

	// result checker: the receiver never stalls, so every done is a transfer
	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
		if (exp !== got) begin
			$display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: mask %h compare %h", $realtime,
				         woken_mask, compare_value);
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("woken_mask", e.woken_mask, woken_mask);
				check_field("any_woken", 32'(e.any_woken), 32'(any_woken));
				check_field("top_priority", 32'(e.top_priority), 32'(top_priority));
				check_field("compare_value", 32'(e.compare_value), 32'(compare_value));
				check_field("must_block", 32'(e.must_block), 32'(must_block));
				check_field("epoch_now", e.epoch_now, epoch_now);
			end
		end
	end

	// hand-picked corner cases at the reset settings
	task automatic test_directed();
		send_command(make_cmd(OP_SETUP, 1, 0, 0, 0, 0, 1, 8'd7));
		send_command(make_cmd(OP_SETUP, 2, 0, 0, 0, 0, 1, 8'd255));
		send_command(make_cmd(OP_SETUP, 31, 0, 0, 0, 0, 1, 8'd0));
		send_command(make_cmd(OP_SETUP, 0, 0, 0, 0, 0, 1, 8'd200));
		send_command(make_cmd(OP_SETUP, 5, 0, 0, 0, 0, 0, 8'd99));
		// just beyond the guard: sleeps and lowers the compare value
		send_command(make_cmd(OP_SLEEP, 1, 0, 25'd141, 25'd100, 0, 0, 0));
		// exactly at the guard: returns at once
		send_command(make_cmd(OP_SLEEP, 2, 0, 25'd140, 25'd100, 0, 0, 0));
		// inside the guard but waiting on an object: blocks anyway
		send_command(make_cmd(OP_SLEEP, 2, 0, 25'd120, 25'd100, 1, 0, 0));
		send_command(make_cmd(OP_SLEEP, 31, 32'd1, 25'h1FFFFFF, 25'd0, 0, 0, 0));
		send_command(make_cmd(OP_SLEEP, 0, 0, 25'd10, 25'd0, 1, 0, 0));
		send_command(make_cmd(OP_SLEEP, 5, 0, 25'd10, 25'd0, 1, 0, 0));
		send_command(make_cmd(OP_MATCH, 0, 0, 0, 25'd0, 0, 0, 0));
		send_command(make_cmd(OP_MATCH, 0, 0, 0, 25'h1FFFFFF, 0, 0, 0));
		send_command(make_cmd(OP_SLEEP, 2, 32'hFFFFFFFF, 25'd5, 25'd0, 0, 0, 0));
		send_command(make_cmd(OP_OVERFLOW, 0, 0, 0, 25'd0, 0, 0, 0));
		// wake epoch now in the past: nothing armed, older wake time kept
		send_command(make_cmd(OP_SLEEP, 1, 32'd0, 25'd50, 25'd0, 0, 0, 0));
		send_command(make_cmd(OP_SLEEP, 1, 32'd1, 25'd50, 25'd0, 0, 0, 0));
		send_command(make_cmd(OP_SLEEP, 3, 32'd1, 25'd60, 25'd0, 1, 0, 0));
		send_command(make_cmd(OP_SETUP, 3, 0, 0, 0, 0, 1, 8'd255));
		send_command(make_cmd(OP_SLEEP, 3, 32'd1, 25'd60, 25'd0, 1, 0, 0));
		send_command(make_cmd(OP_MATCH, 0, 0, 0, 25'd60, 0, 0, 0));
		send_command(make_cmd(OP_OVERFLOW, 0, 0, 0, 25'h1FFFFFF, 0, 0, 0));
		drain_results();
	endtask

	// random traffic in one register setting
	task automatic test_random(input int count, input bit with_idle);
		for (int n = 0; n < count; n++) begin
			if (with_idle && n % 40 == 0)
				idle_on = $urandom_range(0, 2) != 0;
			else if (!with_idle)
				idle_on = 1'b0;
			send_command(random_command());
		end
		drain_results();
	endtask

	task automatic test_register_sweep();
		// shortest epoch and no guard
		write_register(REG_EPOCH_USEC, 32'd1000000);
		write_register(REG_GUARD_USEC, 32'd0);
		test_random(250, 1'b1);
		// longest epoch and widest guard
		write_register(REG_EPOCH_USEC, 32'd33554431);
		write_register(REG_GUARD_USEC, 32'd1023);
		test_random(250, 1'b1);
		write_register(REG_EPOCH_USEC, $urandom_range(1000000, 33554431));
		write_register(REG_GUARD_USEC, $urandom_range(0, 1023));
		test_random(250, 1'b1);
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		opcode           = OP_SLEEP;
		task_req         = '0;
		wake_epoch       = '0;
		wake_usec        = '0;
		timer_now        = '0;
		blocks_on_object = 1'b0;
		enable           = 1'b0;
		priority_req     = '0;
		cfg_valid        = 1'b0;
		cfg_index        = REG_EPOCH_USEC;
		cfg_data         = '0;
		fail_count       = 0;
		cycle_count      = 0;
		idle_on          = 1'b1;
		clear_wake_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 1'b1);
		test_register_sweep();
		// closing stretch with back-to-back transfers
		test_random(250, 1'b0);

		if (fail_count == 0)
			$display("[sleep_wake_scanner_top] OK");
		else
			$display("[sleep_wake_scanner_top] ERROR");
		$finish;
	end

endmodule
